@@ hdl/sdm_pkg.sv @@
package sdm_pkg;

  // debounce counter width and its saturation value
  localparam int COUNT_BITS = 4;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // configuration field widths
  localparam int THR_BITS   = 4;
  localparam int TEMP_BITS  = 16;
  localparam int HUM_BITS   = 14;
  localparam int PRESS_BITS = 17;
  localparam int STAT_BITS  = 8;
  localparam int FLAG_BITS  = 2;

  // apb port geometry
  localparam int NUM_REGS  = 5;
  localparam int ADDR_BITS = $clog2(NUM_REGS * 4);
  localparam int IDX_BITS  = ADDR_BITS - 2;
  localparam int DATA_BITS = 32;

  // width used to compare the raw threshold against the counter range
  localparam int CMP_BITS = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;
  localparam logic [CMP_BITS-1:0] MIN_THR = CMP_BITS'(2);
  localparam logic [CMP_BITS-1:0] MAX_THR = CMP_BITS'(COUNT_MAX);

  // register reset values
  localparam logic [THR_BITS-1:0]          RUN_LIMIT_RST        = THR_BITS'(3);
  localparam logic signed [TEMP_BITS-1:0]  TEMP_HIGH_LIMIT_RST  = 16'sd5000;
  localparam logic [HUM_BITS-1:0]          HUM_HIGH_LIMIT_RST   = HUM_BITS'(8000);
  localparam logic [PRESS_BITS-1:0]        PRESS_LOW_LIMIT_RST  = PRESS_BITS'(95000);
  localparam logic [PRESS_BITS-1:0]        PRESS_HIGH_LIMIT_RST = PRESS_BITS'(106000);

  // quality flag codes that mean a bad sample
  localparam logic [FLAG_BITS-1:0] FLAG_RANGE_ERR = 2'd1;
  localparam logic [FLAG_BITS-1:0] FLAG_RATE_ERR  = 2'd2;

  // register index, taken from paddr above the byte offset
  typedef enum logic [IDX_BITS-1:0] {
    REG_RUN_LIMIT,
    REG_TEMP_HIGH_LIMIT,
    REG_HUM_HIGH_LIMIT,
    REG_PRESS_LOW_LIMIT,
    REG_PRESS_HIGH_LIMIT
  } reg_idx_t;

  // per-debouncer control from the top level
  typedef struct packed {
    logic step;
    logic cond;
  } deb_ctrl_t;

  // threshold clamped to at least 2 and at most the counter range
  function automatic logic [COUNT_BITS-1:0] eff_threshold(logic [THR_BITS-1:0] raw);
    logic [CMP_BITS-1:0] t;
    t = CMP_BITS'(raw);
    if (t < MIN_THR) t = MIN_THR;
    if (t > MAX_THR) t = MAX_THR;
    return COUNT_BITS'(t);
  endfunction

  function automatic logic flag_bad(logic [FLAG_BITS-1:0] f);
    return (f == FLAG_RANGE_ERR) || (f == FLAG_RATE_ERR);
  endfunction

endpackage

@@ hdl/sdm_if.sv @@
interface sdm_tick_if;
  import sdm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [STAT_BITS-1:0]          comm_status;
  logic [FLAG_BITS-1:0]          temp_flag;
  logic [FLAG_BITS-1:0]          press_flag;
  logic [FLAG_BITS-1:0]          hum_flag;
  logic signed [TEMP_BITS-1:0]   temperature;
  logic [PRESS_BITS-1:0]         pressure;
  logic [HUM_BITS-1:0]           humidity;

  modport source (output valid, comm_status, temp_flag, press_flag, hum_flag,
                  temperature, pressure, humidity, input ready);
  modport sink   (input valid, comm_status, temp_flag, press_flag, hum_flag,
                  temperature, pressure, humidity, output ready);
endinterface

interface sdm_status_if;
  logic valid;
  logic ready;
  logic comm_fault;
  logic data_fault;
  logic env_warning;

  modport source (output valid, comm_fault, data_fault, env_warning, input ready);
  modport sink   (input valid, comm_fault, data_fault, env_warning, output ready);
endinterface

@@ hdl/sdm_debounce.sv @@
module sdm_debounce (
  input  logic                           clk,
  input  logic                           rst,
  input  sdm_pkg::deb_ctrl_t             ctrl,
  input  logic [sdm_pkg::COUNT_BITS-1:0] threshold,
  output logic                           flag_next
);
  import sdm_pkg::*;

  typedef enum logic [1:0] {
    PH_NORMAL,
    PH_ASSERT_DEB,
    PH_ASSERTED,
    PH_RECOVER_DEB
  } phase_t;

  phase_t                phase, phase_next;
  logic [COUNT_BITS-1:0] count, count_next;
  logic [COUNT_BITS-1:0] count_inc;

  // saturating run counter
  assign count_inc = (count < COUNT_MAX) ? count + COUNT_BITS'(1) : count;

  // phase transitions for one tick
  always_comb begin
    phase_next = phase;
    count_next = count;
    case (phase)
      PH_NORMAL: begin
        if (ctrl.cond) begin
          phase_next = PH_ASSERT_DEB;
          count_next = COUNT_BITS'(1);
        end
      end
      PH_ASSERT_DEB: begin
        if (!ctrl.cond) begin
          phase_next = PH_NORMAL;
          count_next = '0;
        end else if (count_inc >= threshold) begin
          phase_next = PH_ASSERTED;
          count_next = '0;
        end else begin
          count_next = count_inc;
        end
      end
      PH_ASSERTED: begin
        if (!ctrl.cond) begin
          phase_next = PH_RECOVER_DEB;
          count_next = COUNT_BITS'(1);
        end
      end
      PH_RECOVER_DEB: begin
        if (ctrl.cond) begin
          phase_next = PH_ASSERTED;
          count_next = '0;
        end else if (count_inc >= threshold) begin
          phase_next = PH_NORMAL;
          count_next = '0;
        end else begin
          count_next = count_inc;
        end
      end
      default: begin
        phase_next = PH_NORMAL;
        count_next = '0;
      end
    endcase
  end

  // flag stays up through recovery debounce
  assign flag_next = (phase_next == PH_ASSERTED) || (phase_next == PH_RECOVER_DEB);

  // state update, only when a tick moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_NORMAL;
      count <= '0;
    end else if (ctrl.step) begin
      phase <= phase_next;
      count <= count_next;
    end
  end

`ifndef NO_ASSERTIONS
  // settled phases hold a cleared counter
  a_settled_count_zero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_NORMAL || phase == PH_ASSERTED) |-> count == '0)
    else $error("counter not cleared in settled phase");

  // a run in progress has counted at least its first tick
  a_run_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ASSERT_DEB || phase == PH_RECOVER_DEB) |-> count != '0)
    else $error("debounce run with empty counter");

  // no tick, no change
  a_hold_without_step: assert property (@(posedge clk) disable iff (rst)
    !ctrl.step |=> $stable(phase) && $stable(count))
    else $error("debouncer moved without a tick");

  // a held condition keeps a confirmed fault confirmed
  a_asserted_holds: assert property (@(posedge clk) disable iff (rst)
    ctrl.step && ctrl.cond && phase == PH_ASSERTED |=> phase == PH_ASSERTED)
    else $error("confirmed fault dropped while condition present");
`endif

endmodule

@@ hdl/sensor_diag_debounce_monitor.sv @@
// Sensor diagnostic debounce monitor.
// The tick channel carries one diagnostic item per handshake: comm status,
// three quality flags and filtered temperature, pressure and humidity. The
// status channel returns one item per tick with the debounced comm_fault,
// data_fault and env_warning flags. Limits and the debounce threshold sit in
// five 32-bit APB registers at byte addresses 0, 4, 8, 12 and 16; writes
// complete in the access cycle and pready is tied high.
// An accepted tick lands in the input register, then the raw conditions and
// the three debouncer updates are evaluated combinationally into the result
// register, which takes them once it is empty or its item is taken. One tick
// is accepted every cycle while the status receiver keeps up.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more tick; after that tick ready drops until the
// result is taken, so nothing is lost or repeated.
// Synchronous reset empties both registers, returns all debouncers to normal
// with cleared counters and loads the register reset values.
module sensor_diag_debounce_monitor (
  input  logic                          clk,
  input  logic                          rst,
  sdm_tick_if.sink                      tick,
  sdm_status_if.source                  status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sdm_pkg::ADDR_BITS-1:0] paddr,
  input  logic [sdm_pkg::DATA_BITS-1:0] pwdata,
  output logic [sdm_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);
  import sdm_pkg::*;

  // configuration registers
  logic [THR_BITS-1:0]         run_limit;
  logic signed [TEMP_BITS-1:0] temp_high_limit;
  logic [HUM_BITS-1:0]         hum_high_limit;
  logic [PRESS_BITS-1:0]       press_low_limit;
  logic [PRESS_BITS-1:0]       press_high_limit;

  reg_idx_t reg_idx;
  logic     cfg_wr;

  // input register
  logic                        s1_valid;
  logic [STAT_BITS-1:0]        s1_comm_status;
  logic [FLAG_BITS-1:0]        s1_temp_flag;
  logic [FLAG_BITS-1:0]        s1_press_flag;
  logic [FLAG_BITS-1:0]        s1_hum_flag;
  logic signed [TEMP_BITS-1:0] s1_temperature;
  logic [PRESS_BITS-1:0]       s1_pressure;
  logic [HUM_BITS-1:0]         s1_humidity;

  // result register
  logic out_valid;
  logic out_comm_fault;
  logic out_data_fault;
  logic out_env_warning;

  logic                  out_free, s1_adv, tick_take;
  logic                  comm_c, data_c, env_c;
  logic                  comm_flag, data_flag, env_flag;
  logic [COUNT_BITS-1:0] threshold;
  deb_ctrl_t             comm_ctrl, data_ctrl, env_ctrl;

  // apb access
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_limit        <= RUN_LIMIT_RST;
      temp_high_limit  <= TEMP_HIGH_LIMIT_RST;
      hum_high_limit   <= HUM_HIGH_LIMIT_RST;
      press_low_limit  <= PRESS_LOW_LIMIT_RST;
      press_high_limit <= PRESS_HIGH_LIMIT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RUN_LIMIT:        run_limit        <= pwdata[THR_BITS-1:0];
        REG_TEMP_HIGH_LIMIT:  temp_high_limit  <= pwdata[TEMP_BITS-1:0];
        REG_HUM_HIGH_LIMIT:   hum_high_limit   <= pwdata[HUM_BITS-1:0];
        REG_PRESS_LOW_LIMIT:  press_low_limit  <= pwdata[PRESS_BITS-1:0];
        REG_PRESS_HIGH_LIMIT: press_high_limit <= pwdata[PRESS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_RUN_LIMIT:        prdata = DATA_BITS'(run_limit);
      REG_TEMP_HIGH_LIMIT:  prdata = DATA_BITS'($unsigned(temp_high_limit));
      REG_HUM_HIGH_LIMIT:   prdata = DATA_BITS'(hum_high_limit);
      REG_PRESS_LOW_LIMIT:  prdata = DATA_BITS'(press_low_limit);
      REG_PRESS_HIGH_LIMIT: prdata = DATA_BITS'(press_high_limit);
      default:              prdata = '0;
    endcase
  end

  // handshake: result register frees when empty or taken
  assign out_free   = !out_valid || status.ready;
  assign s1_adv     = s1_valid && out_free;
  assign tick.ready = !s1_valid || out_free;
  assign tick_take  = tick.valid && tick.ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      s1_comm_status <= tick.comm_status;
      s1_temp_flag   <= tick.temp_flag;
      s1_press_flag  <= tick.press_flag;
      s1_hum_flag    <= tick.hum_flag;
      s1_temperature <= tick.temperature;
      s1_pressure    <= tick.pressure;
      s1_humidity    <= tick.humidity;
    end
  end

  // raw conditions
  assign comm_c = s1_comm_status != '0;
  assign data_c = flag_bad(s1_temp_flag) || flag_bad(s1_press_flag) ||
                  flag_bad(s1_hum_flag);
  assign env_c  = (s1_temperature > temp_high_limit) ||
                  (s1_humidity > hum_high_limit) ||
                  (s1_pressure < press_low_limit) ||
                  (s1_pressure > press_high_limit);

  assign threshold = eff_threshold(run_limit);

  assign comm_ctrl = '{step: s1_adv, cond: comm_c};
  assign data_ctrl = '{step: s1_adv, cond: data_c};
  assign env_ctrl  = '{step: s1_adv, cond: env_c};

  // one debouncer per condition
  sdm_debounce u_comm_deb (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (comm_ctrl),
    .threshold (threshold),
    .flag_next (comm_flag)
  );

  sdm_debounce u_data_deb (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (data_ctrl),
    .threshold (threshold),
    .flag_next (data_flag)
  );

  sdm_debounce u_env_deb (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (env_ctrl),
    .threshold (threshold),
    .flag_next (env_flag)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_comm_fault  <= comm_flag;
      out_data_fault  <= data_flag;
      out_env_warning <= env_flag;
    end
  end

  assign status.valid       = out_valid;
  assign status.comm_fault  = out_comm_fault;
  assign status.data_fault  = out_data_fault;
  assign status.env_warning = out_env_warning;

endmodule

@@ bench/tb_sensor_diag_debounce_monitor.sv @@
module tb_sensor_diag_debounce_monitor;
  import sdm_pkg::*;

  localparam int RANDOM_PER_PHASE = 114;
  localparam int NUM_PHASES       = 6;
  localparam int NOISE_PCT        = 12;
  localparam int TEMP_MAX  = 32767;
  localparam int TEMP_MIN  = -32768;
  localparam int HUM_MAX   = 16383;
  localparam int PRESS_MAX = 131071;

  // byte addresses above the register file, decoded as unknown indexes
  localparam logic [ADDR_BITS-1:0] UNMAPPED_ADDR_LO = ADDR_BITS'(NUM_REGS * 4);
  localparam logic [ADDR_BITS-1:0] UNMAPPED_ADDR_HI = {{IDX_BITS{1'b1}}, 2'b00};

  // debouncer channels
  localparam int CH_COMM = 0;
  localparam int CH_DATA = 1;
  localparam int CH_ENV  = 2;

  typedef enum logic [1:0] {
    DEB_NORMAL,
    DEB_ASSERT_WAIT,
    DEB_ASSERTED,
    DEB_RECOVER_WAIT
  } deb_phase_t;

  typedef struct {
    logic [STAT_BITS-1:0]        comm_status;
    logic [FLAG_BITS-1:0]        temp_flag;
    logic [FLAG_BITS-1:0]        press_flag;
    logic [FLAG_BITS-1:0]        hum_flag;
    logic signed [TEMP_BITS-1:0] temperature;
    logic [PRESS_BITS-1:0]       pressure;
    logic [HUM_BITS-1:0]         humidity;
  } tick_t;

  typedef struct {
    logic comm_fault;
    logic data_fault;
    logic env_warning;
  } fault_flags_t;

  logic clk = 1'b0;
  logic rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  sdm_tick_if   tick_ch ();
  sdm_status_if status_ch ();

  sensor_diag_debounce_monitor DUT (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .status  (status_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register shadow
  logic [THR_BITS-1:0]          thr_cfg   = RUN_LIMIT_RST;
  logic signed [TEMP_BITS-1:0]  temp_lim  = TEMP_HIGH_LIMIT_RST;
  logic [HUM_BITS-1:0]          hum_lim   = HUM_HIGH_LIMIT_RST;
  logic [PRESS_BITS-1:0]        press_lo  = PRESS_LOW_LIMIT_RST;
  logic [PRESS_BITS-1:0]        press_hi  = PRESS_HIGH_LIMIT_RST;

  // debouncer shadow
  deb_phase_t            deb_phase [3] = '{DEB_NORMAL, DEB_NORMAL, DEB_NORMAL};
  logic [COUNT_BITS-1:0] deb_count [3] = '{'0, '0, '0};

  tick_t        tick_backlog [$];
  fault_flags_t flags_due [$];
  tick_t        in_flight;

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int errors = 0;
  int ticks_accepted = 0;
  int flags_checked = 0;
  int settings_used = 0;
  int held_seen [3] = '{0, 0, 0};

  // stimulus shaping: per-condition level and remaining run length
  bit lvl [3]      = '{0, 0, 0};
  int run_left [3] = '{0, 0, 0};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run length needed to confirm a phase change
  function automatic logic [COUNT_BITS-1:0] confirm_ticks();
    int t;
    t = int'(thr_cfg);
    if (t < 2) t = 2;
    if (t > int'(COUNT_MAX)) t = int'(COUNT_MAX);
    return COUNT_BITS'(t);
  endfunction

  function automatic bit bad_quality(logic [FLAG_BITS-1:0] f);
    return f == FLAG_RANGE_ERR || f == FLAG_RATE_ERR;
  endfunction

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic step_debouncer(int k, bit c);
    logic [COUNT_BITS-1:0] need;
    need = confirm_ticks();
    case (deb_phase[k])
      DEB_NORMAL: begin
        if (c) begin
          deb_phase[k] = DEB_ASSERT_WAIT;
          deb_count[k] = COUNT_BITS'(1);
        end
      end
      DEB_ASSERT_WAIT: begin
        if (c) begin
          if (deb_count[k] != COUNT_MAX) deb_count[k] = deb_count[k] + COUNT_BITS'(1);
          if (deb_count[k] >= need) begin
            deb_phase[k] = DEB_ASSERTED;
            deb_count[k] = '0;
          end
        end else begin
          deb_phase[k] = DEB_NORMAL;
          deb_count[k] = '0;
        end
      end
      DEB_ASSERTED: begin
        if (!c) begin
          deb_phase[k] = DEB_RECOVER_WAIT;
          deb_count[k] = COUNT_BITS'(1);
        end
      end
      default: begin
        if (!c) begin
          if (deb_count[k] != COUNT_MAX) deb_count[k] = deb_count[k] + COUNT_BITS'(1);
          if (deb_count[k] >= need) begin
            deb_phase[k] = DEB_NORMAL;
            deb_count[k] = '0;
          end
        end else begin
          deb_phase[k] = DEB_ASSERTED;
          deb_count[k] = '0;
        end
      end
    endcase
  endtask

  // derive raw conditions for one tick and queue the debounced flags
  task automatic predict_flags(tick_t t);
    bit comm_c;
    bit data_c;
    bit env_c;
    fault_flags_t f;
    comm_c = t.comm_status != '0;
    data_c = bad_quality(t.temp_flag) || bad_quality(t.press_flag) ||
             bad_quality(t.hum_flag);
    env_c  = (t.temperature > temp_lim) || (t.humidity > hum_lim) ||
             (t.pressure < press_lo) || (t.pressure > press_hi);
    step_debouncer(CH_COMM, comm_c);
    step_debouncer(CH_DATA, data_c);
    step_debouncer(CH_ENV, env_c);
    f.comm_fault  = deb_phase[CH_COMM] inside {DEB_ASSERTED, DEB_RECOVER_WAIT};
    f.data_fault  = deb_phase[CH_DATA] inside {DEB_ASSERTED, DEB_RECOVER_WAIT};
    f.env_warning = deb_phase[CH_ENV] inside {DEB_ASSERTED, DEB_RECOVER_WAIT};
    held_seen[CH_COMM] += f.comm_fault;
    held_seen[CH_DATA] += f.data_fault;
    held_seen[CH_ENV]  += f.env_warning;
    flags_due.push_back(f);
  endtask

  function automatic void check_flag(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s mismatch: expected %0b, got %0b", name, want, got);
      errors++;
    end
  endfunction

  // tick source: holds an item until taken, idles at random between items
  always @(posedge clk) begin : tick_driver
    if (rst) begin
      tick_ch.valid <= 1'b0;
    end else begin
      if (tick_ch.valid && tick_ch.ready) begin
        predict_flags(in_flight);
        ticks_accepted++;
      end
      if (!tick_ch.valid || tick_ch.ready) begin
        if (tick_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_flight = tick_backlog.pop_front();
          tick_ch.valid       <= 1'b1;
          tick_ch.comm_status <= in_flight.comm_status;
          tick_ch.temp_flag   <= in_flight.temp_flag;
          tick_ch.press_flag  <= in_flight.press_flag;
          tick_ch.hum_flag    <= in_flight.hum_flag;
          tick_ch.temperature <= in_flight.temperature;
          tick_ch.pressure    <= in_flight.pressure;
          tick_ch.humidity    <= in_flight.humidity;
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // status sink: stalls at random, compares each item with the oldest prediction
  always @(posedge clk) begin : status_monitor
    fault_flags_t want;
    if (rst) begin
      status_ch.ready <= 1'b0;
    end else begin
      status_ch.ready <= $urandom_range(99) >= snk_stall_pct;
      if (status_ch.valid && status_ch.ready) begin
        if (flags_due.size() == 0) begin
          $error("status item with no tick waiting for it");
          errors++;
        end else begin
          want = flags_due.pop_front();
          check_flag("comm_fault", want.comm_fault, status_ch.comm_fault);
          check_flag("data_fault", want.data_fault, status_ch.data_fault);
          check_flag("env_warning", want.env_warning, status_ch.env_warning);
          flags_checked++;
        end
      end
    end
  end

  task automatic bus_write(logic [ADDR_BITS-1:0] addr, logic [DATA_BITS-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_reg(reg_idx_t r, int v);
    bus_write({r, 2'b00}, DATA_BITS'(v));
    case (r)
      REG_RUN_LIMIT:        thr_cfg  = THR_BITS'(v);
      REG_TEMP_HIGH_LIMIT:  temp_lim = TEMP_BITS'(v);
      REG_HUM_HIGH_LIMIT:   hum_lim  = HUM_BITS'(v);
      REG_PRESS_LOW_LIMIT:  press_lo = PRESS_BITS'(v);
      REG_PRESS_HIGH_LIMIT: press_hi = PRESS_BITS'(v);
      default: ;
    endcase
  endtask

  task automatic set_all(int thr, int tl, int hl, int pl, int ph);
    set_reg(REG_RUN_LIMIT, thr);
    set_reg(REG_TEMP_HIGH_LIMIT, tl);
    set_reg(REG_HUM_HIGH_LIMIT, hl);
    set_reg(REG_PRESS_LOW_LIMIT, pl);
    set_reg(REG_PRESS_HIGH_LIMIT, ph);
  endtask

  task automatic queue_tick(int cs, int tf, int pf, int hf, int t, int p, int h);
    tick_t k;
    k.comm_status = STAT_BITS'(cs);
    k.temp_flag   = FLAG_BITS'(tf);
    k.press_flag  = FLAG_BITS'(pf);
    k.hum_flag    = FLAG_BITS'(hf);
    k.temperature = TEMP_BITS'(t);
    k.pressure    = PRESS_BITS'(p);
    k.humidity    = HUM_BITS'(h);
    tick_backlog.push_back(k);
  endtask

  function automatic logic [FLAG_BITS-1:0] ok_flag();
    return $urandom_range(1) ? 2'd3 : 2'd0;
  endfunction

  // random tick: mostly runs of each condition around the threshold, some noise
  task automatic queue_random_tick();
    tick_t k;
    int need;
    int tries;
    bit done;
    need = int'(confirm_ticks());
    if ($urandom_range(99) < NOISE_PCT) begin
      k.comm_status = STAT_BITS'($urandom);
      k.temp_flag   = FLAG_BITS'($urandom);
      k.press_flag  = FLAG_BITS'($urandom);
      k.hum_flag    = FLAG_BITS'($urandom);
      k.temperature = TEMP_BITS'($urandom);
      k.pressure    = PRESS_BITS'($urandom);
      k.humidity    = HUM_BITS'($urandom);
      tick_backlog.push_back(k);
      return;
    end
    for (int c = 0; c < 3; c++) begin
      if (run_left[c] == 0) begin
        lvl[c] = !lvl[c];
        run_left[c] = span(1, 2 * need + 3);
      end
      run_left[c]--;
    end
    // comm condition
    k.comm_status = lvl[CH_COMM] ? STAT_BITS'($urandom_range(255, 1)) : '0;
    // data condition: one of the flags forced bad
    if (lvl[CH_DATA]) begin
      k.temp_flag  = FLAG_BITS'($urandom);
      k.press_flag = FLAG_BITS'($urandom);
      k.hum_flag   = FLAG_BITS'($urandom);
      case ($urandom_range(2))
        0: k.temp_flag  = $urandom_range(1) ? FLAG_RANGE_ERR : FLAG_RATE_ERR;
        1: k.press_flag = $urandom_range(1) ? FLAG_RANGE_ERR : FLAG_RATE_ERR;
        default: k.hum_flag = $urandom_range(1) ? FLAG_RANGE_ERR : FLAG_RATE_ERR;
      endcase
    end else begin
      k.temp_flag  = ok_flag();
      k.press_flag = ok_flag();
      k.hum_flag   = ok_flag();
    end
    // env condition
    if (!lvl[CH_ENV] && press_lo <= press_hi) begin
      k.temperature = TEMP_BITS'(span(TEMP_MIN, int'(temp_lim)));
      k.humidity    = HUM_BITS'(span(0, int'(hum_lim)));
      k.pressure    = PRESS_BITS'(span(int'(press_lo), int'(press_hi)));
      if ($urandom_range(3) == 0) k.temperature = temp_lim;
      if ($urandom_range(3) == 0) k.humidity = hum_lim;
      if ($urandom_range(3) == 0) k.pressure = $urandom_range(1) ? press_lo : press_hi;
    end else begin
      k.temperature = TEMP_BITS'($urandom);
      k.humidity    = HUM_BITS'($urandom);
      k.pressure    = PRESS_BITS'($urandom);
      done = 1'b0;
      for (tries = 0; tries < 8 && !done; tries++) begin
        case ($urandom_range(3))
          0: if (int'(temp_lim) < TEMP_MAX) begin
            k.temperature = TEMP_BITS'(span(int'(temp_lim) + 1, TEMP_MAX));
            done = 1'b1;
          end
          1: if (int'(hum_lim) < HUM_MAX) begin
            k.humidity = HUM_BITS'(span(int'(hum_lim) + 1, HUM_MAX));
            done = 1'b1;
          end
          2: if (press_lo != '0) begin
            k.pressure = PRESS_BITS'(span(0, int'(press_lo) - 1));
            done = 1'b1;
          end
          default: if (int'(press_hi) < PRESS_MAX) begin
            k.pressure = PRESS_BITS'(span(int'(press_hi) + 1, PRESS_MAX));
            done = 1'b1;
          end
        endcase
      end
    end
    tick_backlog.push_back(k);
  endtask

  // wait until every queued tick is taken and every status item checked
  task automatic drain();
    do @(negedge clk);
    while (tick_backlog.size() != 0 || tick_ch.valid || flags_due.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic configure_phase(int ph);
    int a;
    int b;
    case (ph)
      // small threshold, tightest temperature and humidity limits, widest pressure window
      1: set_all(0, TEMP_MIN, 0, 0, PRESS_MAX);
      // largest threshold, loosest limits and an inverted pressure window
      2: begin
        set_all(int'(COUNT_MAX), TEMP_MAX, HUM_MAX, PRESS_MAX, 0);
        bus_write(UNMAPPED_ADDR_LO, $urandom);
        bus_write(UNMAPPED_ADDR_HI, $urandom);
      end
      3: set_all(1, span(TEMP_MIN, TEMP_MAX), $urandom_range(HUM_MAX),
                 $urandom_range(PRESS_MAX), $urandom_range(PRESS_MAX));
      4: set_all(2, 2500, 6000, 90000, 110000);
      5: begin
        a = $urandom_range(PRESS_MAX);
        b = $urandom_range(PRESS_MAX);
        set_all($urandom_range(15), span(TEMP_MIN, TEMP_MAX), $urandom_range(HUM_MAX),
                a < b ? a : b, a < b ? b : a);
      end
      default: ;
    endcase
    case (ph % 4)
      1: begin src_idle_pct = 58; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 58; end
      3: begin src_idle_pct = 16; snk_stall_pct = 16; end
      default: begin src_idle_pct = 0; snk_stall_pct = 0; end
    endcase
    settings_used++;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      configure_phase(ph);
      if (ph == 0) begin
        // reset limits: boundaries, flag codes, assert and recovery aborts
        queue_tick(8'hFF, 3, 3, 3, 5000, 95000, 8000);
        queue_tick(8'h01, 0, 0, 0, TEMP_MIN, 106000, 0);
        queue_tick(8'h80, 1, 0, 0, 2000, 100000, 5000);
        queue_tick(8'h00, 0, 0, 0, 2000, 100000, 5000);
        queue_tick(8'h55, 0, 2, 0, 5001, 100000, 5000);
        queue_tick(8'h00, 0, 0, 1, TEMP_MAX, 100000, 5000);
        queue_tick(8'h00, 2, 1, 2, 2000, 100000, 8001);
        queue_tick(8'h00, 0, 0, 0, 2000, 100000, HUM_MAX);
        queue_tick(8'h00, 3, 0, 3, 2000, 94999, 5000);
        queue_tick(8'h00, 0, 3, 0, 2000, 0, 5000);
        queue_tick(8'h00, 0, 0, 0, 2000, 106001, 5000);
        queue_tick(8'h00, 0, 0, 0, 2000, PRESS_MAX, 5000);
        queue_tick(8'h00, 0, 0, 0, 2000, 100000, 5000);
        queue_tick(8'h00, 0, 0, 0, -1, 100000, 5000);
        queue_tick(8'h00, 0, 0, 0, 2000, 100000, 5000);
        queue_tick(8'hAA, 1, 1, 1, TEMP_MAX, PRESS_MAX, HUM_MAX);
        queue_tick(8'hAA, 2, 2, 2, TEMP_MAX, 0, HUM_MAX);
        queue_tick(8'h00, 0, 0, 0, 0, 100000, 0);
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) queue_random_tick();
      drain();
    end

    $display("covered %0d ticks under %0d register settings, %0d status items checked",
             ticks_accepted, settings_used, flags_checked);
    $display("asserted flags predicted: comm %0d, data %0d, env %0d",
             held_seen[CH_COMM], held_seen[CH_DATA], held_seen[CH_ENV]);
    if (errors == 0 && flags_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
